// ===== design/hpp_pkg.sv =====
// Package for the hysteresis peak picker: shared constants, register codes
// and the control struct that drives the sorted peak cell chain.
// No dependencies.
package hpp_pkg;

    localparam int HPP_MAX_PEAKS = 16;

    localparam int COST_W  = 16;
    localparam int SCORE_W = 18;
    localparam int RATIO_W = 16;
    localparam int PW_W    = 5;

    localparam logic signed [SCORE_W-1:0] SCORE_ONE = 18'sd16384;
    localparam logic signed [SCORE_W-1:0] SCORE_NEG = -18'sd131072;
    localparam logic signed [SCORE_W-1:0] SCORE_POS = 18'sd131071;
    localparam logic signed [COST_W-1:0]  COST_POS  = 16'sd32767;

    localparam logic [PW_W-1:0]          PEAKS_WANTED_RST   = 5'd1;
    localparam logic [RATIO_W-1:0]       DROP_RATIO_RST     = 16'd58982;
    localparam logic signed [COST_W-1:0] HARD_THRESHOLD_RST = 16'sd8192;

    typedef enum logic [1:0] {
        REG_PEAKS_WANTED   = 2'd0,
        REG_DROP_RATIO     = 2'd1,
        REG_HARD_THRESHOLD = 2'd2
    } hpp_reg_t;

    typedef struct packed {
        logic ins;
        logic shl;
    } hpp_ctl_t;

endpackage

// ===== design/hpp_cell.sv =====
// One slot of the sorted peak list: holds a (cost, lag) pair, decides its
// own insert position and shifts toward the head during readout.
// Depends on hpp_pkg.
module hpp_cell (
    input  logic                                aclk,
    input  hpp_pkg::hpp_ctl_t                   ctl,
    input  logic signed [hpp_pkg::COST_W-1:0]   new_cost,
    input  logic signed [hpp_pkg::COST_W-1:0]   new_lag,
    input  logic                                occ,
    input  logic                                prev_in,
    input  logic signed [hpp_pkg::COST_W-1:0]   prev_cost,
    input  logic signed [hpp_pkg::COST_W-1:0]   prev_lag,
    input  logic signed [hpp_pkg::COST_W-1:0]   next_cost,
    input  logic signed [hpp_pkg::COST_W-1:0]   next_lag,
    output logic                                cell_in,
    output logic signed [hpp_pkg::COST_W-1:0]   cost,
    output logic signed [hpp_pkg::COST_W-1:0]   lag
);
    import hpp_pkg::*;

    logic signed [COST_W-1:0] cost_reg, cost_next;
    logic signed [COST_W-1:0] lag_reg, lag_next;
    logic                     less;

    assign less    = (new_cost < cost_reg) || ((new_cost == cost_reg) && (new_lag < lag_reg));
    assign cell_in = !occ || less;

    always_comb begin
        cost_next = cost_reg;
        lag_next  = lag_reg;
        if (ctl.ins) begin
            if (cell_in && !prev_in) begin
                cost_next = new_cost;
                lag_next  = new_lag;
            end else if (prev_in) begin
                cost_next = prev_cost;
                lag_next  = prev_lag;
            end
        end else if (ctl.shl) begin
            cost_next = next_cost;
            lag_next  = next_lag;
        end
    end

    always_ff @(posedge aclk) begin
        cost_reg <= cost_next;
        lag_reg  <= lag_next;
    end

    assign cost = cost_reg;
    assign lag  = lag_reg;

endmodule

// ===== design/hpp_chain.sv =====
// Row of hpp_cell slots forming the ascending peak list; head is slot 0.
// Depends on hpp_pkg and hpp_cell.
module hpp_chain #(
    parameter int MAX_PEAKS = hpp_pkg::HPP_MAX_PEAKS
) (
    input  logic                                aclk,
    input  hpp_pkg::hpp_ctl_t                   ctl,
    input  logic signed [hpp_pkg::COST_W-1:0]   new_cost,
    input  logic signed [hpp_pkg::COST_W-1:0]   new_lag,
    input  logic [MAX_PEAKS-1:0]                occ,
    output logic signed [hpp_pkg::COST_W-1:0]   head_cost,
    output logic signed [hpp_pkg::COST_W-1:0]   head_lag
);
    import hpp_pkg::*;

    logic signed [COST_W-1:0] cost_a [MAX_PEAKS];
    logic signed [COST_W-1:0] lag_a  [MAX_PEAKS];
    logic                     in_a   [MAX_PEAKS];

    for (genvar i = 0; i < MAX_PEAKS; i++) begin : g_cell
        logic                     p_in;
        logic signed [COST_W-1:0] p_cost, p_lag, n_cost, n_lag;

        if (i == 0) begin : g_head
            assign p_in   = 1'b0;
            assign p_cost = new_cost;
            assign p_lag  = new_lag;
        end else begin : g_body
            assign p_in   = in_a[i-1];
            assign p_cost = cost_a[i-1];
            assign p_lag  = lag_a[i-1];
        end

        if (i == MAX_PEAKS - 1) begin : g_tail
            assign n_cost = cost_a[i];
            assign n_lag  = lag_a[i];
        end else begin : g_mid
            assign n_cost = cost_a[i+1];
            assign n_lag  = lag_a[i+1];
        end

        hpp_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .new_cost  (new_cost),
            .new_lag   (new_lag),
            .occ       (occ[i]),
            .prev_in   (p_in),
            .prev_cost (p_cost),
            .prev_lag  (p_lag),
            .next_cost (n_cost),
            .next_lag  (n_lag),
            .cell_in   (in_a[i]),
            .cost      (cost_a[i]),
            .lag       (lag_a[i])
        );
    end

    assign head_cost = cost_a[0];
    assign head_lag  = lag_a[0];

endmodule

// ===== design/hysteresis_peak_picker_top_n_unit.sv =====
// Top level of the hysteresis peak picker: config registers, peak tracker,
// sequencer and output register around the sorted cell chain.
// Depends on hpp_pkg and hpp_chain.

// Each item runs these steps before the next is accepted: register the item,
// update the running max/min and global minimum, form the two hysteresis
// products, then compare and insert a kept peak into the cell chain in one
// step. The tracker's multiply-then-compare sequence sets these steps.
// On the item marked tlast a further step sizes the report, then results leave
// at one per cycle (slowed by m_tready): up to peaks_wanted peaks (0 acts
// as 1, MAX_PEAKS at most) in ascending (cost, lag) order, or the stream's
// global minimum flagged on tuser when no peak was kept. The next stream's
// first item is taken once the last result sits in the output register.
module hysteresis_peak_picker_top_n_unit #(
    parameter int MAX_PEAKS = hpp_pkg::HPP_MAX_PEAKS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] cost, [31:16] lag
    input  logic        s_tlast,   // final_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] peak_cost, [31:16] peak_lag
    output logic        m_tuser,   // is_fallback
    output logic        m_tlast,   // last_result
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hpp_pkg::*;

    localparam int CNT_W = $clog2(MAX_PEAKS + 1);
    localparam int CMP_W = (CNT_W > PW_W) ? CNT_W : PW_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_TRACK = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_DEC   = 6'b001000,
        ST_PREP  = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [PW_W-1:0]           pw_reg;
    logic [RATIO_W-1:0]        drop_reg;
    logic signed [COST_W-1:0]  thr_reg;

    logic signed [COST_W-1:0]  item_cost_reg, item_lag_reg;
    logic signed [SCORE_W-1:0] item_score_reg;
    logic                      item_fin_reg;

    logic signed [SCORE_W-1:0] score_max_reg, score_min_reg;
    logic signed [COST_W-1:0]  max_cost_reg, max_lag_reg;
    logic signed [COST_W-1:0]  gmin_cost_reg, gmin_lag_reg;
    logic                      seeking_reg;
    logic [CNT_W-1:0]          cnt_reg;

    logic signed [34:0]        prod_max_reg;
    logic signed [36:0]        prod_min_reg;

    logic [CNT_W-1:0]          emit_left_reg;
    logic                      fb_reg;

    logic                      out_valid_reg;
    logic signed [COST_W-1:0]  out_cost_reg, out_lag_reg;
    logic                      out_fb_reg, out_last_reg;

    logic                      accept, cfg_wr, out_free, stream_done;
    logic signed [SCORE_W-1:0] in_score, keep_lim;
    logic [SCORE_W-1:0]        min_factor;
    logic [CMP_W-1:0]          pw_ext;
    logic [CNT_W-1:0]          cap;
    logic                      close_hit, restart_hit, keep_hit;
    logic [MAX_PEAKS-1:0]      occ;
    hpp_ctl_t                  ctl;
    logic signed [COST_W-1:0]  head_cost, head_lag;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pw_reg   <= PEAKS_WANTED_RST;
            drop_reg <= DROP_RATIO_RST;
            thr_reg  <= HARD_THRESHOLD_RST;
        end else if (cfg_wr) begin
            unique case (hpp_reg_t'(paddr[3:2]))
                REG_PEAKS_WANTED:   pw_reg   <= pwdata[PW_W-1:0];
                REG_DROP_RATIO:     drop_reg <= pwdata[RATIO_W-1:0];
                REG_HARD_THRESHOLD: thr_reg  <= pwdata[COST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (hpp_reg_t'(paddr[3:2]))
            REG_PEAKS_WANTED:   prdata = {{(32-PW_W){1'b0}}, pw_reg};
            REG_DROP_RATIO:     prdata = {{(32-RATIO_W){1'b0}}, drop_reg};
            REG_HARD_THRESHOLD: prdata = {{(32-COST_W){thr_reg[COST_W-1]}}, thr_reg};
            default:            prdata = '0;
        endcase
    end

    // list capacity from peaks_wanted
    always_comb begin
        pw_ext = CMP_W'(pw_reg);
        if (pw_ext == '0) begin
            cap = CNT_W'(1);
        end else if (pw_ext > CMP_W'(MAX_PEAKS)) begin
            cap = CNT_W'(MAX_PEAKS);
        end else begin
            cap = pw_ext[CNT_W-1:0];
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_PEAKS; i++) begin
            occ[i] = CNT_W'(i) < cnt_reg;
        end
    end

    // handshake and arithmetic
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign in_score = SCORE_ONE - {{(SCORE_W-COST_W){s_tdata[15]}}, s_tdata[15:0]};
    assign keep_lim = SCORE_ONE - {{(SCORE_W-COST_W){thr_reg[COST_W-1]}}, thr_reg};
    assign min_factor = 18'd131072 - {2'b00, drop_reg};

    assign close_hit   = $signed({item_score_reg[SCORE_W-1], item_score_reg, 16'b0})
                         < prod_max_reg;
    assign restart_hit = $signed({{3{item_score_reg[SCORE_W-1]}}, item_score_reg, 16'b0})
                         > prod_min_reg;
    assign keep_hit    = score_max_reg > keep_lim;

    assign stream_done = (state_reg == ST_EMIT) && out_free
                         && (fb_reg || (emit_left_reg == CNT_W'(1)));

    assign ctl.ins = (state_reg == ST_DEC) && seeking_reg && close_hit && keep_hit;
    assign ctl.shl = (state_reg == ST_EMIT) && out_free && !fb_reg;

    hpp_chain #(
        .MAX_PEAKS (MAX_PEAKS)
    ) u_chain (
        .aclk      (aclk),
        .ctl       (ctl),
        .new_cost  (max_cost_reg),
        .new_lag   (max_lag_reg),
        .occ       (occ),
        .head_cost (head_cost),
        .head_lag  (head_lag)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_TRACK;
            ST_TRACK: state_next = ST_MUL;
            ST_MUL:   state_next = ST_DEC;
            ST_DEC:   state_next = item_fin_reg ? ST_PREP : ST_IDLE;
            ST_PREP:  state_next = ST_EMIT;
            ST_EMIT:  if (stream_done) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // item capture and products
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_cost_reg  <= s_tdata[15:0];
            item_lag_reg   <= s_tdata[31:16];
            item_score_reg <= in_score;
            item_fin_reg   <= s_tlast;
        end
        if (state_reg == ST_MUL) begin
            prod_max_reg <= score_max_reg * $signed({1'b0, drop_reg});
            prod_min_reg <= score_min_reg * $signed({1'b0, min_factor});
        end
        if (state_reg == ST_PREP) begin
            fb_reg        <= (cnt_reg == '0);
            emit_left_reg <= (cnt_reg < cap) ? cnt_reg : cap;
        end else if (ctl.shl) begin
            emit_left_reg <= emit_left_reg - CNT_W'(1);
        end
    end

    // tracker state
    always_ff @(posedge aclk) begin
        if (!aresetn || stream_done) begin
            score_max_reg <= SCORE_NEG;
            score_min_reg <= SCORE_POS;
            seeking_reg   <= 1'b1;
            cnt_reg       <= '0;
            gmin_cost_reg <= COST_POS;
            gmin_lag_reg  <= '0;
        end else begin
            if (state_reg == ST_TRACK) begin
                if ((score_max_reg == SCORE_NEG) || (item_cost_reg < gmin_cost_reg)
                    || ((item_cost_reg == gmin_cost_reg) && (item_lag_reg < gmin_lag_reg))) begin
                    gmin_cost_reg <= item_cost_reg;
                    gmin_lag_reg  <= item_lag_reg;
                end
                if (item_score_reg > score_max_reg) begin
                    score_max_reg <= item_score_reg;
                    max_cost_reg  <= item_cost_reg;
                    max_lag_reg   <= item_lag_reg;
                end
                if (item_score_reg < score_min_reg) begin
                    score_min_reg <= item_score_reg;
                end
            end
            if (state_reg == ST_DEC) begin
                if (seeking_reg) begin
                    if (close_hit) begin
                        score_min_reg <= item_score_reg;
                        seeking_reg   <= 1'b0;
                        if (keep_hit && (cnt_reg < cap)) begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                    end
                end else if (restart_hit) begin
                    score_max_reg <= item_score_reg;
                    max_cost_reg  <= item_cost_reg;
                    max_lag_reg   <= item_lag_reg;
                    seeking_reg   <= 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if ((state_reg == ST_EMIT) && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_EMIT) && out_free) begin
            out_cost_reg <= fb_reg ? gmin_cost_reg : head_cost;
            out_lag_reg  <= fb_reg ? gmin_lag_reg : head_lag;
            out_fb_reg   <= fb_reg;
            out_last_reg <= fb_reg || (emit_left_reg == CNT_W'(1));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_lag_reg, out_cost_reg};
    assign m_tuser  = out_fb_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_PEAKS))
        else $error("peak count beyond list depth");

    a_fb_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("fallback item not marked last");

    a_emit_left: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EMIT) && !fb_reg) |-> (emit_left_reg != '0))
        else $error("list readout with nothing left");

    a_no_take_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EMIT) || (state_reg == ST_PREP)) |-> !s_tready)
        else $error("input taken during report");
`endif

endmodule

// ===== sim/tb_hysteresis_peak_picker_top_n_unit.sv =====
// Self-checking testbench for hysteresis_peak_picker_top_n_unit: streams of
// correlation costs go in, reported peaks are checked against a local predictor.
// Depends on hpp_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_hysteresis_peak_picker_top_n_unit;
    import hpp_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic signed [15:0] cost;
        logic signed [15:0] lag;
        logic               fallback;
        logic               last;
    } peak_rpt_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor configuration and per-stream state
    logic [PW_W-1:0]           want_pw;
    logic [RATIO_W-1:0]        want_ratio;
    logic signed [COST_W-1:0]  want_thresh;
    logic signed [SCORE_W-1:0] sc_max;
    logic signed [SCORE_W-1:0] sc_min;
    logic signed [15:0]        mx_cost;
    logic signed [15:0]        mx_lag;
    logic                      seeking;
    logic signed [15:0]        list_cost [HPP_MAX_PEAKS];
    logic signed [15:0]        list_lag [HPP_MAX_PEAKS];
    int unsigned               list_n;
    logic signed [15:0]        gm_cost;
    logic signed [15:0]        gm_lag;

    peak_rpt_t expected_peaks[$];

    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int mismatches = 0;
    int results_seen = 0;
    int items_sent = 0;
    int streams_sent = 0;
    int reg_writes = 0;
    int cycle_count = 0;

    hysteresis_peak_picker_top_n_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("hysteresis_peak_picker_top_n_unit test failed");
        $finish;
    end

    function automatic int draw_gap(input bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 16));
    endfunction

    function automatic bit pair_below(input logic signed [15:0] ca, input logic signed [15:0] la,
                                      input logic signed [15:0] cb, input logic signed [15:0] lb);
        return (ca < cb) || (ca == cb && la < lb);
    endfunction

    function automatic int unsigned list_capacity();
        if (want_pw == 0) return 1;
        if (want_pw > HPP_MAX_PEAKS) return HPP_MAX_PEAKS;
        return want_pw;
    endfunction

    task automatic clear_stream_state();
        sc_max = SCORE_NEG;
        sc_min = SCORE_POS;
        mx_cost = '0;
        mx_lag = '0;
        seeking = 1'b1;
        list_n = 0;
        gm_cost = COST_POS;
        gm_lag = '0;
    endtask

    task automatic insert_peak(input logic signed [15:0] c, input logic signed [15:0] l);
        int unsigned pos;
        int unsigned cnt;
        pos = 0;
        cnt = list_n;
        while (pos < cnt && !pair_below(c, l, list_cost[pos], list_lag[pos])) pos++;
        if (cnt < list_capacity()) begin
            cnt++;
        end else if (pos >= cnt) begin
            return;
        end
        for (int unsigned i = cnt - 1; i > pos; i--) begin
            list_cost[i] = list_cost[i-1];
            list_lag[i] = list_lag[i-1];
        end
        list_cost[pos] = c;
        list_lag[pos] = l;
        list_n = cnt;
    endtask

    task automatic predict_peaks(input logic signed [15:0] cost, input logic signed [15:0] lag,
                                 input logic fin);
        logic signed [SCORE_W-1:0] score;
        longint scaled;
        int unsigned cnt;
        peak_rpt_t r;
        score = SCORE_ONE - cost;
        scaled = longint'(score) * 65536;
        if (sc_max == SCORE_NEG || pair_below(cost, lag, gm_cost, gm_lag)) begin
            gm_cost = cost;
            gm_lag = lag;
        end
        if (score > sc_max) begin
            sc_max = score;
            mx_cost = cost;
            mx_lag = lag;
        end
        if (score < sc_min) sc_min = score;
        if (seeking) begin
            if (scaled < longint'(sc_max) * longint'(want_ratio)) begin
                if (int'(sc_max) > 16384 - int'(want_thresh)) insert_peak(mx_cost, mx_lag);
                sc_min = score;
                seeking = 1'b0;
            end
        end else if (scaled > longint'(sc_min) * (131072 - longint'(want_ratio))) begin
            sc_max = score;
            mx_cost = cost;
            mx_lag = lag;
            seeking = 1'b1;
        end
        if (fin) begin
            if (list_n == 0) begin
                r = '{cost: gm_cost, lag: gm_lag, fallback: 1'b1, last: 1'b1};
                expected_peaks = {expected_peaks, r};
            end else begin
                cnt = (list_n > list_capacity()) ? list_capacity() : list_n;
                for (int unsigned i = 0; i < cnt; i++) begin
                    r = '{cost: list_cost[i], lag: list_lag[i], fallback: 1'b0,
                          last: (i + 1 == cnt)};
                    expected_peaks = {expected_peaks, r};
                end
            end
            clear_stream_state();
        end
    endtask

    // entered and left right after a rising edge; valid stays high into the next item
    task automatic send_item(input logic signed [15:0] cost, input logic signed [15:0] lag,
                             input logic fin);
        int gap;
        gap = draw_gap(tx_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {lag, cost};
        s_tlast <= fin;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        predict_peaks(cost, lag, fin);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_peaks.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input hpp_reg_t idx, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] readback;
        wait_idle();
        mask = (idx == REG_PEAKS_WANTED) ? 32'h1F : 32'hFFFF;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(negedge aclk); while (!pready);
        @(posedge aclk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(negedge aclk); while (!pready);
        readback = prdata;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_PEAKS_WANTED:   want_pw = value[PW_W-1:0];
            REG_DROP_RATIO:     want_ratio = value[RATIO_W-1:0];
            REG_HARD_THRESHOLD: want_thresh = value[COST_W-1:0];
            default: ;
        endcase
        reg_writes++;
        if ((readback & mask) !== (value & mask)) begin
            mismatches++;
            if (mismatches <= 10)
                $display("register %s: expected %0h, read %0h", idx.name(), value & mask,
                         readback & mask);
        end
    endtask

    task automatic set_config(input logic [4:0] pw, input logic [15:0] ratio,
                              input logic [15:0] thresh);
        cfg_write(REG_PEAKS_WANTED, {27'd0, pw});
        cfg_write(REG_DROP_RATIO, {16'd0, ratio});
        cfg_write(REG_HARD_THRESHOLD, {16'd0, thresh});
    endtask

    task automatic run_stream(input int len, input bit shaped);
        logic signed [15:0] cost;
        logic signed [15:0] lag;
        bit low;
        int run_left;
        lag = 16'($urandom);
        low = 1'b1;
        run_left = $urandom_range(1, 3);
        tx_quiet = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
            if (shaped) begin
                cost = low ? 16'($urandom_range(0, 24000) - 16384)
                           : 16'($urandom_range(8192, 32767));
                lag = lag + 16'($urandom_range(1, 64));
                run_left--;
                if (run_left == 0) begin
                    low = !low;
                    run_left = $urandom_range(1, 3);
                end
            end else begin
                cost = 16'($urandom);
                lag = 16'($urandom);
            end
            send_item(cost, lag, i == len - 1);
        end
        streams_sent++;
    endtask

    task automatic test_field_extremes();
        tx_quiet = 1'b0;
        send_item(-16'sd32768, -16'sd32768, 1'b0);
        send_item(16'sd32767, 16'sd100, 1'b0);
        send_item(16'sd0, 16'sd200, 1'b0);
        send_item(16'sd32767, 16'sd32767, 1'b1);
        send_item(16'sd32767, -16'sd1, 1'b1);
        streams_sent += 2;
    endtask

    task automatic test_equal_peaks();
        set_config(5'd4, 16'd58982, 16'd8192);
        tx_quiet = 1'b1;
        send_item(16'sd100, 16'sd7, 1'b0);
        send_item(16'sd30000, 16'sd8, 1'b0);
        send_item(16'sd100, 16'sd7, 1'b0);
        send_item(16'sd30000, 16'sd9, 1'b0);
        send_item(16'sd100, 16'sd7, 1'b0);
        send_item(16'sd30000, 16'sd10, 1'b0);
        send_item(16'sd30000, 16'sd11, 1'b1);
        streams_sent++;
    endtask

    task automatic test_full_list_drop();
        set_config(5'd2, 16'd58982, 16'd8192);
        tx_quiet = 1'b0;
        send_item(16'sd300, 16'sd1, 1'b0);
        send_item(16'sd30000, 16'sd2, 1'b0);
        send_item(16'sd200, 16'sd3, 1'b0);
        send_item(16'sd30000, 16'sd4, 1'b0);
        send_item(16'sd100, 16'sd5, 1'b0);
        send_item(16'sd30000, 16'sd6, 1'b0);
        send_item(16'sd200, 16'sd7, 1'b0);
        send_item(16'sd30000, 16'sd8, 1'b1);
        streams_sent++;
    endtask

    task automatic test_no_peak_fallback();
        set_config(5'd3, 16'd58982, 16'h8000);
        send_item(16'sd5000, 16'sd10, 1'b0);
        send_item(16'sd5000, 16'sd3, 1'b0);
        send_item(16'sd20000, 16'sd4, 1'b0);
        send_item(16'sd5000, -16'sd2, 1'b1);
        streams_sent++;
    endtask

    task automatic test_register_extremes();
        logic [4:0]  pw_set [5] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd8};
        logic [15:0] ratio_set [5] = '{16'd0, 16'd65535, 16'd32768, 16'd58982, 16'd62000};
        logic [15:0] thr_set [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'd8192, 16'd12000};
        for (int k = 0; k < 5; k++) begin
            set_config(pw_set[k], ratio_set[k], thr_set[k]);
            run_stream($urandom_range(4, 14), 1'b1);
            run_stream($urandom_range(1, 6), 1'b0);
        end
    endtask

    task automatic test_random_streams();
        int start_items;
        logic [15:0] ratio;
        logic [15:0] thresh;
        start_items = items_sent;
        while (items_sent - start_items < 60) begin
            if ($urandom_range(0, 3) == 0) begin
                ratio = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(45000, 65535));
                thresh = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 16384));
                set_config(5'($urandom_range(1, 16)), ratio, thresh);
            end
            run_stream($urandom_range(1, 20), $urandom_range(0, 4) != 0);
        end
    endtask

    initial begin
        peak_rpt_t want;
        logic signed [15:0] got_cost;
        logic signed [15:0] got_lag;
        logic got_fb;
        logic got_last;
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 31) == 0) rx_quiet = !rx_quiet;
            stall = draw_gap(rx_quiet);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(negedge aclk); while (!m_tvalid);
            got_cost = m_tdata[15:0];
            got_lag = m_tdata[31:16];
            got_fb = m_tuser;
            got_last = m_tlast;
            @(posedge aclk);
            results_seen++;
            if (expected_peaks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: cost %0d lag %0d fallback %0b last %0b",
                             got_cost, got_lag, got_fb, got_last);
            end else begin
                want = expected_peaks.pop_front();
                if (got_cost !== want.cost || got_lag !== want.lag ||
                    got_fb !== want.fallback || got_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d: expected cost %0d lag %0d fallback %0b last %0b",
                                 results_seen, want.cost, want.lag, want.fallback, want.last);
                        $display("    got cost %0d lag %0d fallback %0b last %0b",
                                 got_cost, got_lag, got_fb, got_last);
                    end
                end
            end
        end
    end

    initial begin
        want_pw = PEAKS_WANTED_RST;
        want_ratio = DROP_RATIO_RST;
        want_thresh = HARD_THRESHOLD_RST;
        clear_stream_state();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_field_extremes();
        test_equal_peaks();
        test_full_list_drop();
        test_no_peak_fallback();
        test_register_extremes();
        test_random_streams();

        wait_idle();
        repeat (20) @(posedge aclk);
        if (expected_peaks.size() != 0) begin
            mismatches++;
            $display("%0d expected results never arrived", expected_peaks.size());
        end

        $display("covered %0d streams, %0d items, %0d results, %0d register writes",
                 streams_sent, items_sent, results_seen, reg_writes);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("hysteresis_peak_picker_top_n_unit test passed");
        end else begin
            $display("hysteresis_peak_picker_top_n_unit test failed");
        end
        $finish;
    end

endmodule
